[rtl/hpb_pkg.sv]
// Shared constants and types for the highlighter pixel blend pipeline.
`default_nettype none
package hpb_pkg;
    // Fixed-point format: FRAC_BITS fraction bits, fraction values span 0..ONE.
    localparam int FRAC_BITS = 16;
    localparam int FW = FRAC_BITS + 1;
    localparam int PW = 2 * FW;
    localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Luma weights 0.299, 0.587 and 0.114, rounded to FRAC_BITS.
    localparam int WW = FRAC_BITS;
    localparam longint unsigned W0_L = ((64'd299 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned W1_L = ((64'd587 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam longint unsigned W2_L = ((64'd114 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [WW-1:0] W0 = WW'(W0_L);
    localparam logic [WW-1:0] W1 = WW'(W1_L);
    localparam logic [WW-1:0] W2 = WW'(W2_L);
    localparam int SW = FRAC_BITS + 9;

    // Reciprocal for (n << FRAC_BITS) / 65025, rounded up so the floor is exact.
    localparam int XSH = 33;
    localparam int XRW = FRAC_BITS + 18;
    localparam longint unsigned XR_L = (64'd1 << (FRAC_BITS + XSH)) / 64'd65025 + 64'd1;
    localparam logic [XRW-1:0] XR = XRW'(XR_L);
    localparam int XPW = 16 + XRW;

    // Reciprocal for (alpha << FRAC_BITS) / 255.
    localparam int DSH = 18;
    localparam int DRW = FRAC_BITS + 11;
    localparam longint unsigned DR_L = (64'd1 << (FRAC_BITS + DSH)) / 64'd255 + 64'd1;
    localparam logic [DRW-1:0] DR = DRW'(DR_L);
    localparam int DPW = 8 + DRW;

    // Power stage count (x raised to the 15th takes 14 multiplies).
    localparam int POW_STAGES = 14;

    // Blend numerator width and divider depth.
    localparam int NW = FRAC_BITS + 9;
    localparam int QB = 8;

    // Total latency from accept to result strobe.
    localparam int LATENCY = 3 + POW_STAGES + 2 + QB;

    // Configuration register indexes.
    localparam logic [1:0] REG_BRUSH0 = 2'd0;
    localparam logic [1:0] REG_BRUSH1 = 2'd1;
    localparam logic [1:0] REG_BRUSH2 = 2'd2;

    typedef logic [2:0][7:0] t_bytes;
endpackage
`default_nettype wire

[rtl/hpb_front.sv]
// Front stages: luma, source coverage and destination alpha.
`default_nettype none
module hpb_front
    import hpb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_bytes        i_bytes,
    input  wire logic [7:0]    i_ca,
    input  wire logic [7:0]    i_ma,
    output logic               o_valid,
    output t_bytes             o_bytes,
    output logic [FW-1:0]      o_x,
    output logic [FW-1:0]      o_da
);
    logic [SW-1:0]  n_sum;
    logic [8:0]     n_yw;
    logic [7:0]     n_y;
    logic [DPW-1:0] n_dprod;
    logic [XPW-1:0] n_xprod;

    logic [2:0]     r_v;
    logic [7:0]     r_a_y, r_a_ca, r_a_ma;
    t_bytes         r_a_by, r_b_by, r_c_by;
    logic [15:0]    r_b_n;
    logic [FW-1:0]  r_b_da, r_c_da, r_c_x;

    // Stage A: weighted luma sum, clamped to 255.
    always_comb begin
        n_sum = SW'(W0) * SW'(i_bytes[0]) + SW'(W1) * SW'(i_bytes[1])
              + SW'(W2) * SW'(i_bytes[2]);
        n_yw  = n_sum[SW-1:FRAC_BITS];
        n_y   = (n_yw > 9'd255) ? 8'd255 : n_yw[7:0];
    end

    // Stage B products and stage C reciprocal multiply.
    assign n_dprod = DPW'(r_a_ca) * DPW'(DR);
    assign n_xprod = XPW'(r_b_n) * XPW'(XR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_y  <= n_y;
        r_a_ca <= i_ca;
        r_a_ma <= i_ma;
        r_a_by <= i_bytes;
        r_b_n  <= 16'(r_a_y) * 16'(r_a_ma);
        r_b_da <= n_dprod[DSH+FW-1:DSH];
        r_b_by <= r_a_by;
        r_c_x  <= n_xprod[XSH+FW-1:XSH];
        r_c_da <= r_b_da;
        r_c_by <= r_b_by;
    end

    assign o_valid = r_v[2];
    assign o_bytes = r_c_by;
    assign o_x     = r_c_x;
    assign o_da    = r_c_da;
endmodule
`default_nettype wire

[rtl/hpb_power.sv]
// Power chain: raises the coverage to the 15th, one truncating multiply per stage.
`default_nettype none
module hpb_power
    import hpb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_bytes        i_bytes,
    input  wire logic [FW-1:0] i_x,
    input  wire logic [FW-1:0] i_da,
    output logic               o_valid,
    output t_bytes             o_bytes,
    output logic [FW-1:0]      o_sa,
    output logic [FW-1:0]      o_da
);
    logic [POW_STAGES-1:0] r_v;
    logic [FW-1:0]         r_p  [POW_STAGES];
    logic [FW-1:0]         r_x  [POW_STAGES];
    logic [FW-1:0]         r_da [POW_STAGES];
    t_bytes                r_by [POW_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[POW_STAGES-2:0], i_valid};
        end
    end

    // Each stage multiplies the running power by x and drops the fraction tail.
    for (genvar j = 0; j < POW_STAGES; j++) begin : g_stage
        logic [FW-1:0] s_p, s_x, s_da;
        t_bytes        s_by;
        logic [PW-1:0] n_prod;
        if (j == 0) begin : g_first
            assign s_p  = i_x;
            assign s_x  = i_x;
            assign s_da = i_da;
            assign s_by = i_bytes;
        end else begin : g_next
            assign s_p  = r_p[j-1];
            assign s_x  = r_x[j-1];
            assign s_da = r_da[j-1];
            assign s_by = r_by[j-1];
        end
        assign n_prod = PW'(s_p) * PW'(s_x);
        always_ff @(posedge i_clk) begin
            r_p[j]  <= n_prod[FRAC_BITS+FW-1:FRAC_BITS];
            r_x[j]  <= s_x;
            r_da[j] <= s_da;
            r_by[j] <= s_by;
        end
    end

    assign o_valid = r_v[POW_STAGES-1];
    assign o_bytes = r_by[POW_STAGES-1];
    assign o_sa    = r_p[POW_STAGES-1];
    assign o_da    = r_da[POW_STAGES-1];
endmodule
`default_nettype wire

[rtl/hpb_blend.sv]
// Blend stages: destination weight, result alpha and color numerators.
`default_nettype none
module hpb_blend
    import hpb_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_bytes        i_bytes,
    input  wire t_bytes        i_brush,
    input  wire logic [FW-1:0] i_sa,
    input  wire logic [FW-1:0] i_da,
    output logic               o_valid,
    output logic [2:0][NW-1:0] o_num,
    output logic [FW-1:0]      o_oa,
    output logic [7:0]         o_alpha
);
    logic [1:0]          r_v;
    logic [FW-1:0]       r_d, r_sa, r_oa;
    t_bytes              r_by;
    logic [2:0][NW-1:0]  r_num;
    logic [7:0]          r_alpha;
    logic [PW-1:0]       n_dprod;
    logic [FW-1:0]       n_oa;
    logic [FW+7:0]       n_aprod;
    logic [2:0][NW-1:0]  n_num;

    // Stage D: canvas contribution d = dstA * (1 - srcA).
    assign n_dprod = PW'(i_da) * PW'(ONE - i_sa);

    // Stage E: result alpha and the three weighted color sums.
    always_comb begin
        n_oa    = r_sa + r_d;
        n_aprod = (FW+8)'(n_oa) * (FW+8)'(8'd255);
        for (int k = 0; k < 3; k++) begin
            n_num[k] = NW'(i_brush[k]) * NW'(r_sa) + NW'(r_by[k]) * NW'(r_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_dprod[FRAC_BITS+FW-1:FRAC_BITS];
        r_sa    <= i_sa;
        r_by    <= i_bytes;
        r_oa    <= n_oa;
        r_num   <= n_num;
        r_alpha <= n_aprod[FRAC_BITS+7:FRAC_BITS];
    end

    assign o_valid = r_v[1];
    assign o_num   = r_num;
    assign o_oa    = r_oa;
    assign o_alpha = r_alpha;
endmodule
`default_nettype wire

[rtl/hpb_div.sv]
// Pipelined restoring divider: three color lanes share one divisor, one quotient bit a stage.
`default_nettype none
module hpb_div
    import hpb_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [2:0][NW-1:0] i_num,
    input  wire logic [FW-1:0]  i_den,
    input  wire logic [7:0]     i_alpha,
    output logic                o_valid,
    output t_bytes              o_q,
    output logic [7:0]          o_alpha
);
    logic [QB-1:0]       r_v;
    logic [2:0][NW-1:0]  r_rem   [QB];
    t_bytes              r_q     [QB];
    logic [FW-1:0]       r_den   [QB];
    logic [7:0]          r_alpha [QB];
    logic                r_zero  [QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[QB-2:0], i_valid};
        end
    end

    // Stage j settles quotient bit QB-1-j by a compare and subtract.
    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic [2:0][NW-1:0] s_rem, n_rem;
        t_bytes             s_q, n_q;
        logic [FW-1:0]      s_den;
        logic [7:0]         s_alpha;
        logic               s_zero;
        logic [NW-1:0]      s_sh;
        if (j == 0) begin : g_first
            assign s_rem   = i_num;
            assign s_q     = '0;
            assign s_den   = i_den;
            assign s_alpha = i_alpha;
            assign s_zero  = (i_den == '0);
        end else begin : g_next
            assign s_rem   = r_rem[j-1];
            assign s_q     = r_q[j-1];
            assign s_den   = r_den[j-1];
            assign s_alpha = r_alpha[j-1];
            assign s_zero  = r_zero[j-1];
        end
        assign s_sh = NW'(s_den) << (QB - 1 - j);
        always_comb begin
            n_rem = s_rem;
            n_q   = s_q;
            for (int k = 0; k < 3; k++) begin
                if (!s_zero && s_rem[k] >= s_sh) begin
                    n_rem[k]           = s_rem[k] - s_sh;
                    n_q[k][QB - 1 - j] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_rem[j]   <= n_rem;
            r_q[j]     <= n_q;
            r_den[j]   <= s_den;
            r_alpha[j] <= s_alpha;
            r_zero[j]  <= s_zero;
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_q     = r_q[QB-1];
    assign o_alpha = r_alpha[QB-1];
endmodule
`default_nettype wire

[rtl/highlighter_pixel_blend.sv]
// Top level of the highlighter pixel blend: brush color registers and the blend pipeline.
// An accepted pixel runs through the front, power, blend and divider stages.
// Throughput: one pixel per cycle; busy is always low and results cannot be held off.
// Its depth is chiefly the 14-stage power chain and the 8-stage quotient pipeline.
// Reset is synchronous and active low: it clears all valid bits and loads the brush
// color registers with 0, 255, 255.
`default_nettype none
module highlighter_pixel_blend
    import hpb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] i_canvas_byte_0,
    input  wire logic [7:0] i_canvas_byte_1,
    input  wire logic [7:0] i_canvas_byte_2,
    input  wire logic [7:0] i_canvas_alpha,
    input  wire logic [7:0] i_mask_alpha,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    output logic            o_valid,
    output logic [7:0]      o_out_byte_0,
    output logic [7:0]      o_out_byte_1,
    output logic [7:0]      o_out_byte_2,
    output logic [7:0]      o_out_alpha
);
    t_bytes             r_brush;
    t_bytes             s_in_bytes, s_f_bytes, s_p_bytes, s_q;
    logic               s_accept, s_f_valid, s_p_valid, s_b_valid;
    logic [FW-1:0]      s_f_x, s_f_da, s_p_sa, s_p_da, s_b_oa;
    logic [2:0][NW-1:0] s_b_num;
    logic [7:0]         s_b_alpha;

    assign busy       = 1'b0;
    assign s_accept   = start && !busy;
    assign s_in_bytes = {i_canvas_byte_2, i_canvas_byte_1, i_canvas_byte_0};

    // Brush color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush <= {8'd255, 8'd255, 8'd0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BRUSH0: r_brush[0] <= i_cfg_data;
                REG_BRUSH1: r_brush[1] <= i_cfg_data;
                REG_BRUSH2: r_brush[2] <= i_cfg_data;
                default:    r_brush    <= r_brush;
            endcase
        end
    end

    hpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_bytes (s_in_bytes),
        .i_ca    (i_canvas_alpha),
        .i_ma    (i_mask_alpha),
        .o_valid (s_f_valid),
        .o_bytes (s_f_bytes),
        .o_x     (s_f_x),
        .o_da    (s_f_da)
    );

    hpb_power u_power (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_f_valid),
        .i_bytes (s_f_bytes),
        .i_x     (s_f_x),
        .i_da    (s_f_da),
        .o_valid (s_p_valid),
        .o_bytes (s_p_bytes),
        .o_sa    (s_p_sa),
        .o_da    (s_p_da)
    );

    hpb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_p_valid),
        .i_bytes (s_p_bytes),
        .i_brush (r_brush),
        .i_sa    (s_p_sa),
        .i_da    (s_p_da),
        .o_valid (s_b_valid),
        .o_num   (s_b_num),
        .o_oa    (s_b_oa),
        .o_alpha (s_b_alpha)
    );

    hpb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_b_valid),
        .i_num   (s_b_num),
        .i_den   (s_b_oa),
        .i_alpha (s_b_alpha),
        .o_valid (o_valid),
        .o_q     (s_q),
        .o_alpha (o_out_alpha)
    );

    assign o_out_byte_0 = s_q[0];
    assign o_out_byte_1 = s_q[1];
    assign o_out_byte_2 = s_q[2];

    // A result strobe always traces back to a transaction a fixed latency earlier.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(s_accept, LATENCY))
        else $error("result strobe without a matching transaction");

    // An accepted transaction always produces its result.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s_accept, LATENCY) && $past(i_rst_n, LATENCY - 1) |-> o_valid)
        else $error("transaction lost in the pipeline");

    // A zero result alpha denominator gives zero colors.
    a_zero_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_alpha == 8'd0 && $past(s_b_oa, QB) == '0 |->
            o_out_byte_0 == 8'd0 && o_out_byte_1 == 8'd0 && o_out_byte_2 == 8'd0)
        else $error("nonzero color with zero result alpha");
endmodule
`default_nettype wire
